/* rtl/brwr_pkg.sv */
// shared constants, codes, types and helpers of the byte ring buffer with rewind
`timescale 1ns / 1ps

package brwr_pkg;

    localparam int STORE_DEPTH  = 4096;
    localparam int MAX_READ_RUN = 64;

    localparam int PTR_W   = $clog2(STORE_DEPTH);
    localparam int CNT_W   = 13;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;
    localparam int SKIP_W  = 14;
    localparam int ACT_W   = 2;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 64;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [CNT_W-1:0] CAP_RESET   = CNT_W'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] LIMIT_RESET = '0;

    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SKIP  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

    localparam logic REG_CAPACITY      = 1'b0;
    localparam logic REG_HISTORY_LIMIT = 1'b1;

    // settings seen by the datapath
    typedef struct packed {
        logic [CNT_W-1:0] eff_cap;
        logic [CNT_W-1:0] hist_limit;
        logic             clear;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic issue;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_valid;
        logic run_ok;
        logic out_free;
        logic run_end;
    } sts_t;

    // capacity minus fill minus history, floored at zero
    function automatic logic [CNT_W-1:0] free_calc(
        input logic [CNT_W-1:0] cap,
        input logic [CNT_W-1:0] fill,
        input logic [CNT_W-1:0] hist
    );
        logic [CNT_W:0] used;
        used = (CNT_W+1)'(fill) + (CNT_W+1)'(hist);
        if (used >= (CNT_W+1)'(cap))
            return '0;
        return CNT_W'((CNT_W+1)'(cap) - used);
    endfunction

endpackage

/* rtl/byte_ring_buffer_with_rewind_core.sv */
// top level of the byte ring buffer with rewind history
`timescale 1ns / 1ps

// channel   signals                        carries
// s_*       tvalid tready tdata tuser      one command item in
// m_*       tvalid tready tdata tlast      result items out
// apb       psel penable pwrite paddr ...  capacity (0x0), history limit (0x4)
//
// write, skip, clear, empty and refused reads: the item is held in the input
// register, then the result loads into the output register
// a read run of n bytes is started from the input register, then for each byte the
// store read is registered, then the byte moves to the output register
// the next item is taken in while a read run is still emitting
// one item waits in the input register while the output register is stalled
// reset: capacity 4096, history limit 0, pointers and counts zero, no clearing pass

module byte_ring_buffer_with_rewind_core
    import brwr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // data_byte, read_length, skip_amount
    input  logic [ACT_W-1:0]    s_tuser,   // action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // status, read_byte, moved_amount,
                                           // fill_level, free_space, history_level
    output logic                m_tlast,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    brwr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    brwr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    brwr_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

/* rtl/brwr_regs.sv */
// apb register bank: capacity and history limit
`timescale 1ns / 1ps

module brwr_regs
    import brwr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] limit_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_CAPACITY:      cap_reg   <= pwdata[CNT_W-1:0];
                REG_HISTORY_LIMIT: limit_reg <= pwdata[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CAPACITY:      prdata = APB_DW'(cap_reg);
            REG_HISTORY_LIMIT: prdata = APB_DW'(limit_reg);
            default:           prdata = '0;
        endcase
    end

    // zero behaves as one, anything past the store as the store size
    always_comb
    begin
        if (cap_reg == '0)
            cfg.eff_cap = CNT_W'(1);
        else if (cap_reg > CNT_W'(STORE_DEPTH))
            cfg.eff_cap = CNT_W'(STORE_DEPTH);
        else
            cfg.eff_cap = cap_reg;
        cfg.hist_limit = limit_reg;
        // a capacity write also resets pointers and counts
        cfg.clear      = wr_en && (paddr[2] == REG_CAPACITY);
    end

endmodule

/* rtl/brwr_ctrl.sv */
// controller: sequences single-result items and byte-by-byte read runs
`timescale 1ns / 1ps

module brwr_ctrl
    import brwr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sts.item_valid && sts.out_free)
                begin
                    cmd.exec = 1'b1;
                    if (sts.run_ok)
                        state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                // memory read of the next byte
                cmd.issue  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.run_end ? ST_IDLE : ST_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/brwr_dp.sv */
// datapath: item register, byte store, pointers, counts and output register
`timescale 1ns / 1ps

module brwr_dp
    import brwr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [ACT_W-1:0]    s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    input  cfg_t                cfg,
    input  cmd_t                cmd,
    output sts_t                sts
);

    logic [BYTE_W-1:0] byte_store [STORE_DEPTH];

    // held item
    logic              item_valid_reg;
    logic [ACT_W-1:0]  act_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [SKIP_W-1:0] skip_reg;

    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  hist_reg;

    logic [LEN_W-1:0]  run_len_reg;
    logic [LEN_W-1:0]  remain_reg;
    logic [BYTE_W-1:0] rd_data_reg;

    logic              out_valid_reg;
    logic              out_status_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic [SKIP_W-1:0] out_moved_reg;
    logic [CNT_W-1:0]  out_fill_reg;
    logic [CNT_W-1:0]  out_free_reg;
    logic [CNT_W-1:0]  out_hist_reg;

    // outcome of the held item
    logic              ex_status;
    logic [SKIP_W-1:0] ex_moved;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [CNT_W-1:0]  fill_next;
    logic [CNT_W-1:0]  hist_next;
    logic              ex_run;
    logic              ex_mem_we;

    logic [PTR_W-1:0]  rd_inc;
    logic [PTR_W-1:0]  wr_inc;
    logic [CNT_W:0]    used;
    logic [CNT_W:0]    hist_sum;
    logic              skip_neg;
    logic [SKIP_W-1:0] skip_mag;
    logic [SKIP_W:0]   fwd_sum;
    logic [SKIP_W:0]   bwd_wrap;
    logic              out_free;
    logic              single_load;

    assign s_tready = !item_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            item_valid_reg <= 1'b1;
        else if (cmd.exec)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            act_reg  <= s_tuser;
            data_reg <= s_tdata[BYTE_W-1:0];
            len_reg  <= s_tdata[BYTE_W +: LEN_W];
            skip_reg <= s_tdata[BYTE_W+LEN_W +: SKIP_W];
        end
    end

    // single-step advance wraps at the capacity
    always_comb
    begin
        rd_inc = ((CNT_W)'(rd_ptr_reg) + CNT_W'(1) >= cfg.eff_cap) ? '0
                 : PTR_W'((CNT_W)'(rd_ptr_reg) + CNT_W'(1));
        wr_inc = ((CNT_W)'(wr_ptr_reg) + CNT_W'(1) >= cfg.eff_cap) ? '0
                 : PTR_W'((CNT_W)'(wr_ptr_reg) + CNT_W'(1));
    end

    assign used     = (CNT_W+1)'(fill_reg) + (CNT_W+1)'(hist_reg);
    assign hist_sum = (CNT_W+1)'(hist_reg) + (CNT_W+1)'(len_reg);
    assign skip_neg = skip_reg[SKIP_W-1];
    assign skip_mag = skip_neg ? (~skip_reg + 1'b1) : skip_reg;
    assign fwd_sum  = (SKIP_W+1)'(rd_ptr_reg) + (SKIP_W+1)'(skip_mag);
    assign bwd_wrap = (SKIP_W+1)'(rd_ptr_reg) + (SKIP_W+1)'(cfg.eff_cap)
                      - (SKIP_W+1)'(skip_mag);

    always_comb
    begin
        ex_status   = 1'b0;
        ex_moved    = '0;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        hist_next   = hist_reg;
        ex_run      = 1'b0;
        ex_mem_we   = 1'b0;
        unique case (act_reg)
            ACT_WRITE:
            begin
                if (used >= (CNT_W+1)'(cfg.eff_cap))
                    ex_status = 1'b1;
                else
                begin
                    ex_mem_we   = 1'b1;
                    wr_ptr_next = wr_inc;
                    fill_next   = fill_reg + CNT_W'(1);
                    ex_moved    = SKIP_W'(1);
                end
            end
            ACT_READ:
            begin
                if (len_reg == '0)
                    ex_status = 1'b0;
                else if (len_reg > LEN_W'(MAX_READ_RUN)
                         || CNT_W'(len_reg) > fill_reg)
                    ex_status = 1'b1;
                else
                begin
                    ex_run    = 1'b1;
                    fill_next = fill_reg - CNT_W'(len_reg);
                    hist_next = (hist_sum > (CNT_W+1)'(cfg.hist_limit)) ? cfg.hist_limit
                                : CNT_W'(hist_sum);
                end
            end
            ACT_SKIP:
            begin
                if (!skip_neg)
                begin
                    if (skip_mag > SKIP_W'(fill_reg))
                        ex_status = 1'b1;
                    else
                    begin
                        rd_ptr_next = (fwd_sum >= (SKIP_W+1)'(cfg.eff_cap))
                                      ? PTR_W'(fwd_sum - (SKIP_W+1)'(cfg.eff_cap))
                                      : PTR_W'(fwd_sum);
                        fill_next   = fill_reg - CNT_W'(skip_mag);
                        ex_moved    = skip_reg;
                    end
                end
                else
                begin
                    if (skip_mag > SKIP_W'(hist_reg))
                        ex_status = 1'b1;
                    else
                    begin
                        rd_ptr_next = (SKIP_W'(rd_ptr_reg) < skip_mag)
                                      ? PTR_W'(bwd_wrap)
                                      : PTR_W'(SKIP_W'(rd_ptr_reg) - skip_mag);
                        hist_next   = hist_reg - CNT_W'(skip_mag);
                        fill_next   = fill_reg + CNT_W'(skip_mag);
                        ex_moved    = skip_reg;
                    end
                end
            end
            ACT_CLEAR:
            begin
                rd_ptr_next = '0;
                wr_ptr_next = '0;
                fill_next   = '0;
                hist_next   = '0;
            end
            default:
            begin
                ex_status = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
            hist_reg   <= '0;
        end
        else if (cfg.clear)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
            hist_reg   <= '0;
        end
        else if (cmd.exec)
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
            hist_reg   <= hist_next;
        end
        else if (cmd.issue)
        begin
            rd_ptr_reg <= rd_inc;
        end
    end

    // byte store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.exec && ex_mem_we)
            byte_store[wr_ptr_reg] <= data_reg;
        if (cmd.issue)
            rd_data_reg <= byte_store[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            remain_reg <= '0;
        else if (cmd.exec && ex_run)
            remain_reg <= len_reg;
        else if (cmd.issue)
            remain_reg <= remain_reg - LEN_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && ex_run)
            run_len_reg <= len_reg;
    end

    assign out_free    = !out_valid_reg || m_tready;
    assign single_load = cmd.exec && !ex_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (single_load || cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (single_load)
        begin
            out_status_reg <= ex_status;
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b1;
            out_moved_reg  <= ex_moved;
            out_fill_reg   <= fill_next;
            out_free_reg   <= free_calc(cfg.eff_cap, fill_next, hist_next);
            out_hist_reg   <= hist_next;
        end
        else if (cmd.emit)
        begin
            // counts were already settled when the run started
            out_status_reg <= 1'b0;
            out_byte_reg   <= rd_data_reg;
            out_last_reg   <= (remain_reg == '0);
            out_moved_reg  <= SKIP_W'(run_len_reg);
            out_fill_reg   <= fill_reg;
            out_free_reg   <= free_calc(cfg.eff_cap, fill_reg, hist_reg);
            out_hist_reg   <= hist_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_DATA_W'({out_hist_reg, out_free_reg, out_fill_reg,
                                 out_moved_reg, out_byte_reg, out_status_reg});

    assign sts.item_valid = item_valid_reg;
    assign sts.run_ok     = ex_run;
    assign sts.out_free   = out_free;
    assign sts.run_end    = (remain_reg == '0);

endmodule
